// ----- sv/kbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Kinematic bicycle step package
// Shared constants, state encoding and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package kbs_pkg;

  localparam int CordicStepsDefault = 16;
  localparam int AtanLen = 24;

  localparam logic [31:0] GainQ30 = 32'd652032874;
  localparam logic [29:0] RadToBamQ16 = 30'd683565276;

  // Configuration register indexes.
  localparam logic [1:0] CfgMaxSteer = 2'd0;
  localparam logic [1:0] CfgMaxAccel = 2'd1;
  localparam logic [1:0] CfgMaxDecel = 2'd2;
  localparam logic [1:0] CfgWheelbase = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CS_HEAD,      // CORDIC on the old heading
    ST_PROJ_X,       // vx*cos
    ST_PROJ_Y,       // vy*sin, sum and saturate
    ST_STEER_MUL,
    ST_ACC_MUL,
    ST_DV_MUL,
    ST_CS_BETA,      // CORDIC on steer+heading
    ST_VX_MUL,
    ST_VY_MUL,
    ST_PX_MUL,
    ST_PY_MUL,
    ST_CS_STEER,     // CORDIC on steer
    ST_D_MUL,
    ST_X_MUL,
    ST_K_MUL_LO,
    ST_K_MUL_HI,
    ST_DIV,
    ST_DONE
  } state_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    begin
      case (idx)
        5'd0: r = 32'd536870912;
        5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;
        5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;
        5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;
        5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;
        5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41721;
        5'd15: r = 32'd20860;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2607;
        5'd19: r = 32'd1303;
        5'd20: r = 32'd651;
        5'd21: r = 32'd325;
        5'd22: r = 32'd162;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/kbs_cordic.sv -----
// ----------------------------------------------------------------------------
// Kinematic bicycle CORDIC
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving the
// cosine and sine of a 16-bit binary angle in Q2.30.
// ----------------------------------------------------------------------------
`default_nettype none

module kbs_cordic import kbs_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] angle,
  output logic             done,
  output logic signed [33:0] cos_q30,
  output logic signed [33:0] sin_q30
);

  localparam int Steps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;

  logic               busy;
  logic [4:0]         step;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic               flip;
  logic [31:0]        z32;
  logic               fold;

  assign z32  = {angle, 16'd0};
  assign fold = (z32 > 32'h4000_0000) && (z32 < 32'hC000_0000);

  // One micro-rotation per cycle, then a sign flip for the folded half turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= 34'(signed'({1'b0, GainQ30}));
        y    <= '0;
        flip <= fold;
        z    <= 34'(signed'(fold ? (z32 - 32'h8000_0000) : z32));
      end else if (busy) begin
        if (step == 5'(Steps)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (flip) begin
            x <= -x;
            y <= -y;
          end
        end else begin
          if (!z[33]) begin
            x <= x - (y >>> step);
            y <= y + (x >>> step);
            z <= z - 34'(signed'({2'b00, atan_turn(step)}));
          end else begin
            x <= x + (y >>> step);
            y <= y - (x >>> step);
            z <= z + 34'(signed'({2'b00, atan_turn(step)}));
          end
          step <= step + 5'd1;
        end
      end
    end
  end

  assign cos_q30 = x;
  assign sin_q30 = y;

endmodule

`default_nettype wire

// ----- sv/kinematic_bicycle_step.sv -----
// ----------------------------------------------------------------------------
// Kinematic bicycle step
// Advances a fixed-point bicycle model by one time tick per input item.
//
// Usage: an input item (tick_dt, has_command, steer_cmd, accel_cmd) is taken
// when in_valid is high and in_stall is low. in_stall is high from then until
// the result item has been taken on the output channel (out_valid high,
// out_stall low). Each item makes three passes of the shared CORDIC, uses
// the shared multiplier (skipping the steering and acceleration products
// without a command) and runs the one-bit-a-cycle heading divider, which is
// skipped when the wheelbase is zero. The result register holds its item
// while out_stall is high; a new input item is taken only after it is
// delivered. Configuration writes (cfg_we, cfg_index, cfg_data) take effect
// at once and belong to idle periods. Reset clears the vehicle state to zero
// and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module kinematic_bicycle_step import kbs_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        tick_dt,
  input  wire logic               has_command,
  input  wire logic signed [15:0] steer_cmd,
  input  wire logic signed [15:0] accel_cmd,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      out_pos_x,
  output logic signed [47:0]      out_pos_y,
  output logic [15:0]             out_heading,
  output logic signed [31:0]      out_speed,
  output logic signed [15:0]      out_steer
);

  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  // Configuration registers.
  logic [14:0] max_steer;
  logic [30:0] max_accel;
  logic [30:0] max_decel;
  logic [30:0] wheelbase;

  // Vehicle state.
  logic signed [31:0] velocity_x;
  logic signed [31:0] velocity_y;
  logic [15:0]        heading_angle;
  logic signed [15:0] steer_angle;
  logic signed [47:0] position_x;
  logic signed [47:0] position_y;

  // Working registers of one item.
  state_t             state;
  state_t             state_next;
  logic [15:0]        dt;
  logic               cmd;
  logic signed [15:0] sc;
  logic signed [15:0] ac;
  logic signed [63:0] acc;      // product accumulator
  logic signed [31:0] v;
  logic signed [31:0] accel;
  logic signed [47:0] dx;       // x term of heading change
  logic signed [95:0] num;      // dividend magnitude
  logic               neg;
  logic [47:0]        quo;
  logic [47:0]        rem;
  logic [5:0]         div_cnt;

  // Shared multiplier operands, 34 x 34 bits signed.
  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] prod;

  // CORDIC interface.
  logic               cs_start;
  logic [15:0]        cs_angle;
  logic               cs_done;
  logic signed [33:0] cs_cos;
  logic signed [33:0] cs_sin;
  logic signed [33:0] cos_r;
  logic signed [33:0] sin_r;

  kbs_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cs_start),
    .angle   (cs_angle),
    .done    (cs_done),
    .cos_q30 (cs_cos),
    .sin_q30 (cs_sin)
  );

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    if (a > S32Max) return 32'sh7FFF_FFFF;
    if (a < S32Min) return 32'sh8000_0000;
    return a[31:0];
  endfunction

  assign prod = ma * mb;

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_PROJ_X: begin
        ma = 34'(velocity_x);
        mb = cos_r;
      end
      ST_PROJ_Y: begin
        ma = 34'(velocity_y);
        mb = sin_r;
      end
      ST_STEER_MUL: begin
        ma = 34'(sc);
        mb = 34'(signed'({1'b0, max_steer}));
      end
      ST_ACC_MUL: begin
        ma = 34'(ac);
        mb = (ac > 0 || v <= 0) ? 34'(signed'({1'b0, max_accel}))
                                : 34'(signed'({1'b0, max_decel}));
      end
      ST_DV_MUL: begin
        ma = 34'(signed'({1'b0, dt}));
        mb = 34'(accel);
      end
      ST_VX_MUL: begin
        ma = 34'(v);
        mb = cos_r;
      end
      ST_VY_MUL: begin
        ma = 34'(v);
        mb = sin_r;
      end
      ST_PX_MUL: begin
        ma = 34'(signed'({1'b0, dt}));
        mb = 34'(velocity_x);
      end
      ST_PY_MUL: begin
        ma = 34'(signed'({1'b0, dt}));
        mb = 34'(velocity_y);
      end
      ST_D_MUL: begin
        ma = 34'(signed'({1'b0, dt}));
        mb = 34'(v);
      end
      ST_X_MUL: begin
        ma = 34'(acc);
        mb = sin_r;
      end
      ST_K_MUL_LO: begin
        ma = 34'(signed'({1'b0, dx[23:0]}));
        mb = 34'(signed'({1'b0, RadToBamQ16}));
      end
      ST_K_MUL_HI: begin
        ma = 34'(dx >>> 24);
        mb = 34'(signed'({1'b0, RadToBamQ16}));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    cs_start   = 1'b0;
    cs_angle   = heading_angle;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CS_HEAD;
          cs_start   = 1'b1;
        end
      end
      ST_CS_HEAD: if (cs_done) state_next = ST_PROJ_X;
      ST_PROJ_X: state_next = ST_PROJ_Y;
      ST_PROJ_Y: state_next = cmd ? ST_STEER_MUL : ST_DV_MUL;
      ST_STEER_MUL: state_next = ST_ACC_MUL;
      ST_ACC_MUL: state_next = ST_DV_MUL;
      ST_DV_MUL: begin
        state_next = ST_CS_BETA;
        cs_start   = 1'b1;
        cs_angle   = 16'(steer_angle) + heading_angle;
      end
      ST_CS_BETA: if (cs_done) state_next = ST_VX_MUL;
      ST_VX_MUL: state_next = ST_VY_MUL;
      ST_VY_MUL: state_next = ST_PX_MUL;
      ST_PX_MUL: state_next = ST_PY_MUL;
      ST_PY_MUL: begin
        state_next = ST_CS_STEER;
        cs_start   = 1'b1;
        cs_angle   = 16'(steer_angle);
      end
      ST_CS_STEER: if (cs_done) state_next = ST_D_MUL;
      ST_D_MUL: state_next = ST_X_MUL;
      ST_X_MUL: state_next = ST_K_MUL_LO;
      ST_K_MUL_LO: state_next = ST_K_MUL_HI;
      ST_K_MUL_HI: state_next = (wheelbase == '0) ? ST_DONE : ST_DIV;
      ST_DIV: if (div_cnt == 6'd0) state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath and state updates.
  logic signed [63:0] p64;
  logic signed [63:0] p14;
  logic signed [63:0] steer_lim;
  logic signed [63:0] acc_lim;
  logic signed [63:0] dv;
  logic signed [95:0] kprod;
  logic [48:0]        rem_sh;
  logic [47:0]        divisor;
  logic               q_bit;
  logic [47:0]        quo_fin;
  assign p64       = prod[63:0];
  assign p14       = p64 >>> 14;
  assign steer_lim = 64'(signed'({1'b0, max_steer}));
  assign acc_lim   = (ac > 0 || v <= 0) ? 64'(signed'({1'b0, max_accel}))
                                        : 64'(signed'({1'b0, max_decel}));
  assign kprod     = (96'(prod) <<< 24) + num;
  assign divisor   = {1'b0, wheelbase, 16'd0};
  assign rem_sh    = {rem, num[63]};
  assign q_bit     = (rem_sh >= {1'b0, divisor});
  assign quo_fin   = {quo[46:0], q_bit};

  // Speed change, with braking from a forward speed stopping at zero.
  always_comb begin
    dv = p64 >>> 16;
    if (v > 0 && dv < -64'(v)) dv = -64'(v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_steer     <= 15'd5461;
      max_accel     <= 31'd19660800;
      max_decel     <= 31'd39321600;
      wheelbase     <= 31'd18350080;
      velocity_x    <= '0;
      velocity_y    <= '0;
      heading_angle <= '0;
      steer_angle   <= '0;
      position_x    <= '0;
      position_y    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgMaxSteer: max_steer <= cfg_data[14:0];
          CfgMaxAccel: max_accel <= cfg_data;
          CfgMaxDecel: max_decel <= cfg_data;
          CfgWheelbase: wheelbase <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          dt    <= tick_dt;
          cmd   <= has_command;
          sc    <= steer_cmd;
          ac    <= accel_cmd;
          accel <= '0;
        end
        ST_CS_HEAD, ST_CS_BETA, ST_CS_STEER: begin
          cos_r <= cs_cos;
          sin_r <= cs_sin;
        end
        ST_PROJ_X: acc <= p64;
        ST_PROJ_Y: v <= sat32((acc + p64) >>> 30);
        ST_STEER_MUL: begin
          if (sc > 0)
            steer_angle <= 16'(p14 < steer_lim ? p14 : steer_lim);
          else
            steer_angle <= 16'(p14 > -steer_lim ? p14 : -steer_lim);
        end
        ST_ACC_MUL: begin
          if (ac > 0)
            accel <= 32'(p14 < acc_lim ? p14 : acc_lim);
          else
            accel <= 32'(p14 > -acc_lim ? p14 : -acc_lim);
        end
        ST_DV_MUL: v <= sat32(64'(v) + dv);
        ST_VX_MUL: velocity_x <= sat32(p64 >>> 30);
        ST_VY_MUL: velocity_y <= sat32(p64 >>> 30);
        ST_PX_MUL: position_x <= position_x + 48'(p64 >>> 16);
        ST_PY_MUL: position_y <= position_y + 48'(p64 >>> 16);
        ST_D_MUL: acc <= p64 >>> 16;
        ST_X_MUL: dx <= 48'(prod >>> 30);
        ST_K_MUL_LO: num <= 96'(prod);
        ST_K_MUL_HI: begin
          neg   <= kprod[95];
          num   <= kprod[95] ? -kprod : kprod;
          rem   <= '0;
          quo   <= '0;
          div_cnt <= 6'd63;
        end
        ST_DIV: begin
          // Restoring division, one quotient bit per cycle over the low
          // 64 bits; the product stays below 2^63 in magnitude.
          if (q_bit)
            rem <= 48'(rem_sh - {1'b0, divisor});
          else
            rem <= rem_sh[47:0];
          quo <= quo_fin;
          num <= num <<< 1;
          div_cnt <= div_cnt - 6'd1;
        end
        default: ;
      endcase
      if (state == ST_DIV && div_cnt == 6'd0)
        heading_angle <= heading_angle + (neg ? -quo_fin[15:0] : quo_fin[15:0]);
    end
  end

  assign in_stall    = (state != ST_IDLE);
  assign out_valid   = (state == ST_DONE);
  assign out_pos_x   = position_x;
  assign out_pos_y   = position_y;
  assign out_heading = heading_angle;
  assign out_speed   = v;
  assign out_steer   = steer_angle;

  // A result appears only after the sequencer has run through the divider
  // or skipped it.
  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |->
      $past(state) == ST_DIV || $past(state) == ST_K_MUL_HI)
    else $error("result without completed step");

  // A stalled result keeps its heading.
  a_hold_heading: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(heading_angle))
    else $error("heading changed under stall");

  // The CORDIC is only started from idle or between phases.
  a_cordic_start: assert property (@(posedge clk) disable iff (rst)
    cs_start |-> state == ST_IDLE || state == ST_DV_MUL || state == ST_PY_MUL)
    else $error("CORDIC started mid-phase");

endmodule

`default_nettype wire
